[hdl/rbp_pkg.sv]
package rbp_pkg;

  localparam int OP_W   = 3;
  localparam int KEY_W  = 32;
  localparam int POS_W  = 10;
  localparam int CNT_W  = 11;
  localparam int BC_W   = 7;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ADDR_W-3:0] reg_idx_t;

  localparam op_t OP_LOAD    = 3'd0;
  localparam op_t OP_PART    = 3'd1;
  localparam op_t OP_RD_PAIR = 3'd2;
  localparam op_t OP_RD_BKT  = 3'd3;
  localparam op_t OP_CLEAR   = 3'd4;

  localparam reg_idx_t REG_BEGIN = 2'd0;
  localparam reg_idx_t REG_END   = 2'd1;
  localparam reg_idx_t REG_BCNT  = 2'd2;

endpackage

[hdl/rbp_ifs.sv]
interface rbp_req_if;
  logic                                valid;
  logic                                ready;
  rbp_pkg::op_t                        op;
  logic signed [rbp_pkg::KEY_W-1:0]    key;
  logic signed [rbp_pkg::KEY_W-1:0]    value;
  logic        [rbp_pkg::POS_W-1:0]    position;
  modport source (output valid, op, key, value, position, input ready);
  modport sink (input valid, op, key, value, position, output ready);
endinterface

interface rbp_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbp_pkg::KEY_W-1:0]    key_out;
  logic signed [rbp_pkg::KEY_W-1:0]    value_out;
  logic        [rbp_pkg::CNT_W-1:0]    bucket_start;
  logic        [rbp_pkg::CNT_W-1:0]    bucket_size;
  logic        [rbp_pkg::CNT_W-1:0]    item_count;
  logic                                error;
  modport source (output valid, key_out, value_out, bucket_start, bucket_size, item_count,
                  error, input ready);
  modport sink (input valid, key_out, value_out, bucket_start, bucket_size, item_count,
                error, output ready);
endinterface

[hdl/range_bucket_partitioner.sv]
// Load, clear: IDLE, then S_FIN per beat. Read pair / read bucket: IDLE, S_READ, S_FIN.
// Partition: zero the sizes, a counting pass over the N loaded pairs, a prefix sum, then a
// scatter pass; each in-range key goes twice through the shared multiply / restoring divide unit.
// One beat is in work at a time; a result waits in the output register.
// Synchronous active-high reset clears counters and the bucket tables (via a valid flag);
// pair stores are undefined until written.
module range_bucket_partitioner #(
  parameter int MAX_ITEMS   = 1024,
  parameter int MAX_BUCKETS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  rbp_req_if.sink                      req,
  rbp_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [rbp_pkg::DATA_W-1:0]   pwdata,
  output logic [rbp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int NBW = $clog2(MAX_BUCKETS + 1);
  localparam int BIW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW  = 32 + NBW;
  localparam int SW  = (BIW > 1) ? $clog2(BIW) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_READ   = 4'd1;
  localparam logic [3:0] S_ZERO   = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_BKT_RD = 4'd6;
  localparam logic [3:0] S_BKT_WR = 4'd7;
  localparam logic [3:0] S_PFX_RD = 4'd8;
  localparam logic [3:0] S_PFX_WR = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0]                 state;
  logic signed [31:0]         range_begin;
  logic signed [31:0]         range_end;
  logic [rbp_pkg::BC_W-1:0]   bucket_count;
  logic [NBW-1:0]             nb;

  logic [CW-1:0]              fill_count;
  logic [CW-1:0]              ordered_count;
  logic                       clamp_seen;
  logic                       clamp_acc;
  logic                       tbl_valid;
  logic                       scat;
  logic                       res_err;
  rbp_pkg::op_t               op_q;
  logic [rbp_pkg::POS_W-1:0]  pos_q;
  logic [CW-1:0]              idx;
  logic [BIW-1:0]             pidx;
  logic [BIW-1:0]             bk_q;
  logic [CW-1:0]              run;
  logic [NW-1:0]              num;
  logic [NW-1:0]              dsh;
  logic [BIW-1:0]             qv;
  logic [SW-1:0]              dstep;
  logic                       qbit;
  logic [BIW-1:0]             q_next;
  logic [31:0]                diff;
  logic [31:0]                span;

  logic signed [31:0] loaded_keys   [MAX_ITEMS];
  logic signed [31:0] loaded_values [MAX_ITEMS];
  logic signed [31:0] ordered_keys  [MAX_ITEMS];
  logic signed [31:0] ordered_values[MAX_ITEMS];
  logic [CW-1:0]      bucket_sizes  [MAX_BUCKETS];
  logic [CW-1:0]      bucket_starts [MAX_BUCKETS];
  logic [CW-1:0]      bucket_cursor [MAX_BUCKETS];

  logic signed [31:0] ld_key_q, ld_val_q, ord_key_q, ord_val_q;
  logic [CW-1:0]      sz_q, st_q, cur_q;
  logic [BIW-1:0]     bk_addr;
  logic               sz_we, st_we, cur_we, ord_we, ld_we;
  logic [CW-1:0]      sz_wd, pfx_wd;
  logic               pair_ok, bkt_ok, last_item, last_bkt;

  logic signed [31:0]        rsp_key, rsp_val;
  logic [rbp_pkg::CNT_W-1:0] rsp_bs, rsp_bz, rsp_cnt;
  logic                      rsp_err, rsp_valid;

  always_comb begin
    if (bucket_count == '0) begin
      nb = NBW'(1);
    end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
      nb = NBW'(MAX_BUCKETS);
    end else begin
      nb = NBW'(bucket_count);
    end
  end

  assign pready  = 1'b1;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    case (paddr[rbp_pkg::ADDR_W-1:2])
      rbp_pkg::REG_BEGIN: prdata = range_begin;
      rbp_pkg::REG_END:   prdata = range_end;
      rbp_pkg::REG_BCNT:  prdata = {25'd0, bucket_count};
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_ZERO, S_PFX_RD, S_PFX_WR: bk_addr = pidx;
      S_BKT_RD, S_BKT_WR:         bk_addr = bk_q;
      default:                    bk_addr = BIW'(pos_q);
    endcase
  end

  assign diff      = ld_key_q - range_begin;
  assign span      = range_end - range_begin;
  assign qbit      = (num >= dsh);
  assign q_next    = BIW'({qv, qbit});
  assign last_item = ((idx + CW'(1)) == fill_count);
  assign last_bkt  = (pidx == BIW'(MAX_BUCKETS - 1));
  assign pair_ok   = (32'(pos_q) < 32'(ordered_count));
  assign bkt_ok    = (32'(pos_q) < 32'(nb));

  assign ld_we  = (state == S_IDLE) && req.valid && (req.op == rbp_pkg::OP_LOAD) &&
                  (32'(fill_count) < 32'(MAX_ITEMS));
  assign sz_we  = (state == S_ZERO) || ((state == S_BKT_WR) && !scat);
  assign sz_wd  = (state == S_ZERO) ? '0 : sz_q + CW'(1);
  assign st_we  = (state == S_PFX_WR);
  assign pfx_wd = (32'(pidx) < 32'(nb)) ? run : '0;
  assign cur_we = (state == S_PFX_WR) || ((state == S_BKT_WR) && scat);
  assign ord_we = (state == S_BKT_WR) && scat;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      loaded_keys[fill_count[IW-1:0]]   <= req.key;
      loaded_values[fill_count[IW-1:0]] <= req.value;
    end
    ld_key_q <= loaded_keys[idx[IW-1:0]];
    ld_val_q <= loaded_values[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ordered_keys[cur_q[IW-1:0]]   <= ld_key_q;
      ordered_values[cur_q[IW-1:0]] <= ld_val_q;
    end
    ord_key_q <= ordered_keys[IW'(pos_q)];
    ord_val_q <= ordered_values[IW'(pos_q)];
  end

  always_ff @(posedge clk) begin
    if (sz_we) begin
      bucket_sizes[bk_addr] <= sz_wd;
    end
    sz_q <= bucket_sizes[bk_addr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      bucket_starts[bk_addr] <= pfx_wd;
    end
    st_q <= bucket_starts[bk_addr];
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      bucket_cursor[bk_addr] <= (state == S_PFX_WR) ? pfx_wd : cur_q + CW'(1);
    end
    cur_q <= bucket_cursor[bk_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      range_begin   <= '0;
      range_end     <= 32'sh7FFFFFFF;
      bucket_count  <= rbp_pkg::BC_W'(1);
      fill_count    <= '0;
      ordered_count <= '0;
      clamp_seen    <= 1'b0;
      clamp_acc     <= 1'b0;
      tbl_valid     <= 1'b0;
      scat          <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[rbp_pkg::ADDR_W-1:2])
          rbp_pkg::REG_BEGIN: range_begin  <= pwdata;
          rbp_pkg::REG_END:   range_end    <= pwdata;
          rbp_pkg::REG_BCNT:  bucket_count <= pwdata[rbp_pkg::BC_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q  <= req.op;
            pos_q <= req.position;
            case (req.op)
              rbp_pkg::OP_LOAD: begin
                res_err <= !ld_we;
                if (ld_we) fill_count <= fill_count + CW'(1);
                state <= S_FIN;
              end
              rbp_pkg::OP_PART: begin
                pidx      <= '0;
                clamp_acc <= 1'b0;
                scat      <= 1'b0;
                state     <= S_ZERO;
              end
              rbp_pkg::OP_RD_PAIR, rbp_pkg::OP_RD_BKT: begin
                state <= S_READ;
              end
              rbp_pkg::OP_CLEAR: begin
                fill_count    <= '0;
                ordered_count <= '0;
                clamp_seen    <= 1'b0;
                tbl_valid     <= 1'b0;
                state         <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_READ: state <= S_FIN;
        S_ZERO: begin
          if (last_bkt) begin
            pidx <= '0;
            idx  <= '0;
            run  <= '0;
            state <= (fill_count == '0) ? S_PFX_RD : S_FETCH;
          end else begin
            pidx <= pidx + BIW'(1);
          end
        end
        S_FETCH: state <= S_MUL;
        S_MUL: begin
          if (ld_key_q < range_begin) begin
            bk_q      <= '0;
            clamp_acc <= 1'b1;
            state     <= S_BKT_RD;
          end else if (ld_key_q >= range_end) begin
            bk_q      <= BIW'(nb - NBW'(1));
            clamp_acc <= 1'b1;
            state     <= S_BKT_RD;
          end else begin
            num   <= NW'(diff) * NW'(nb);
            dsh   <= NW'(span) << (BIW - 1);
            dstep <= SW'(BIW - 1);
            qv    <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (qbit) num <= num - dsh;
          qv    <= q_next;
          dsh   <= dsh >> 1;
          dstep <= dstep - SW'(1);
          if (dstep == '0) begin
            bk_q  <= q_next;
            state <= S_BKT_RD;
          end
        end
        S_BKT_RD: state <= S_BKT_WR;
        S_BKT_WR: begin
          if (last_item) begin
            idx <= '0;
            if (scat) begin
              ordered_count <= fill_count;
              clamp_seen    <= clamp_acc;
              tbl_valid     <= 1'b1;
              state         <= S_FIN;
            end else begin
              pidx  <= '0;
              run   <= '0;
              state <= S_PFX_RD;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= S_FETCH;
          end
        end
        S_PFX_RD: state <= S_PFX_WR;
        S_PFX_WR: begin
          run <= run + sz_q;
          if (last_bkt) begin
            scat <= 1'b1;
            idx  <= '0;
            if (fill_count == '0) begin
              ordered_count <= fill_count;
              clamp_seen    <= clamp_acc;
              tbl_valid     <= 1'b1;
              state         <= S_FIN;
            end else begin
              state <= S_FETCH;
            end
          end else begin
            pidx  <= pidx + BIW'(1);
            state <= S_PFX_RD;
          end
        end
        S_FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_key   <= '0;
            rsp_val   <= '0;
            rsp_bs    <= '0;
            rsp_bz    <= '0;
            rsp_cnt   <= rbp_pkg::CNT_W'(fill_count);
            case (op_q)
              rbp_pkg::OP_LOAD:  rsp_err <= res_err;
              rbp_pkg::OP_PART:  rsp_err <= clamp_seen;
              rbp_pkg::OP_RD_PAIR: begin
                rsp_err <= !pair_ok;
                if (pair_ok) begin
                  rsp_key <= ord_key_q;
                  rsp_val <= ord_val_q;
                end
              end
              rbp_pkg::OP_RD_BKT: begin
                rsp_err <= !bkt_ok;
                if (bkt_ok && tbl_valid) begin
                  rsp_bs <= rbp_pkg::CNT_W'(st_q);
                  rsp_bz <= rbp_pkg::CNT_W'(sz_q);
                end
              end
              rbp_pkg::OP_CLEAR: rsp_err <= 1'b0;
              default:           rsp_err <= 1'b1;
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.key_out      = rsp_key;
  assign rsp.value_out    = rsp_val;
  assign rsp.bucket_start = rsp_bs;
  assign rsp.bucket_size  = rsp_bz;
  assign rsp.item_count   = rsp_cnt;
  assign rsp.error        = rsp_err;

`ifndef SYNTH
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= 32'(MAX_ITEMS))
    else $error("fill count above store depth");
  a_ord_le_fill: assert property (@(posedge clk) disable iff (rst)
    ordered_count <= fill_count)
    else $error("ordered count above fill count");
  a_bkt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BKT_RD) |-> (32'(bk_q) < 32'(nb)))
    else $error("bucket index out of range");
  a_part_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && op_q == rbp_pkg::OP_PART) |-> (ordered_count == fill_count))
    else $error("partition finished with stale ordered count");
`endif

endmodule

[bench/range_bucket_partitioner_test.sv]
module range_bucket_partitioner_test;

  localparam int MAX_ITEMS   = 1024;
  localparam int MAX_BUCKETS = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [31:0]               key_out;
    logic [31:0]               value_out;
    logic [rbp_pkg::CNT_W-1:0] bucket_start;
    logic [rbp_pkg::CNT_W-1:0] bucket_size;
    logic [rbp_pkg::CNT_W-1:0] item_count;
    logic                      error;
  } rsp_t;

  class partition_scoreboard;
    logic [31:0]               ld_key [MAX_ITEMS];
    logic [31:0]               ld_val [MAX_ITEMS];
    logic [31:0]               ord_key[MAX_ITEMS];
    logic [31:0]               ord_val[MAX_ITEMS];
    logic [rbp_pkg::CNT_W-1:0] bkt_size [MAX_BUCKETS];
    logic [rbp_pkg::CNT_W-1:0] bkt_start[MAX_BUCKETS];
    int unsigned               fill;
    int unsigned               ord_cnt;
    bit                        clamp;
    logic [31:0]               rng_lo;
    logic [31:0]               rng_hi;
    logic [rbp_pkg::BC_W-1:0]  nbkt;
    rsp_t                      pending[$];
    int                        mismatches;

    function new();
      rng_lo = 0;
      rng_hi = 32'h7fff_ffff;
      nbkt = 1;
      fill = 0;
      ord_cnt = 0;
      clamp = 0;
      mismatches = 0;
      foreach (bkt_size[i]) begin
        bkt_size[i] = 0;
        bkt_start[i] = 0;
      end
    endfunction

    function void set_reg(rbp_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        rbp_pkg::REG_BEGIN: rng_lo = v;
        rbp_pkg::REG_END:   rng_hi = v;
        rbp_pkg::REG_BCNT:  nbkt = v[rbp_pkg::BC_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_buckets();
      if (nbkt == 0) return 1;
      if (nbkt > MAX_BUCKETS) return MAX_BUCKETS;
      return nbkt;
    endfunction

    function int unsigned bucket_of(logic [31:0] k, int unsigned nb, inout bit cl);
      logic [31:0] d;
      logic [63:0] num, span;
      if ($signed(k) < $signed(rng_lo)) begin
        cl = 1;
        return 0;
      end
      if ($signed(k) >= $signed(rng_hi)) begin
        cl = 1;
        return nb - 1;
      end
      d = k - rng_lo;
      num = {32'b0, d} * 64'(nb);
      d = rng_hi - rng_lo;
      span = {32'b0, d};
      return int'(num / span);
    endfunction

    function void run_partition();
      int unsigned nb, run, b, dst;
      int unsigned slot[MAX_BUCKETS];
      bit cl;
      nb = eff_buckets();
      run = 0;
      cl = 0;
      foreach (bkt_size[i]) begin
        bkt_size[i] = 0;
        bkt_start[i] = 0;
        slot[i] = 0;
      end
      for (int i = 0; i < fill; i++) begin
        b = bucket_of(ld_key[i], nb, cl);
        bkt_size[b]++;
      end
      for (int i = 0; i < nb; i++) begin
        bkt_start[i] = rbp_pkg::CNT_W'(run);
        run += bkt_size[i];
      end
      for (int i = 0; i < fill; i++) begin
        b = bucket_of(ld_key[i], nb, cl);
        dst = bkt_start[b] + slot[b];
        slot[b]++;
        if (dst < MAX_ITEMS) begin
          ord_key[dst] = ld_key[i];
          ord_val[dst] = ld_val[i];
        end
      end
      ord_cnt = fill;
      clamp = cl;
    endfunction

    function void note_request(rbp_pkg::op_t op, logic [31:0] k, logic [31:0] v,
                               logic [rbp_pkg::POS_W-1:0] pos);
      rsp_t r;
      r = '{key_out: 0, value_out: 0, bucket_start: 0, bucket_size: 0,
            item_count: 0, error: 0};
      case (op)
        rbp_pkg::OP_LOAD: begin
          if (fill < MAX_ITEMS) begin
            ld_key[fill] = k;
            ld_val[fill] = v;
            fill++;
          end else r.error = 1;
        end
        rbp_pkg::OP_PART: begin
          run_partition();
          r.error = clamp;
        end
        rbp_pkg::OP_RD_PAIR: begin
          if (pos < ord_cnt) begin
            r.key_out = ord_key[pos];
            r.value_out = ord_val[pos];
          end else r.error = 1;
        end
        rbp_pkg::OP_RD_BKT: begin
          if (pos < eff_buckets()) begin
            r.bucket_start = bkt_start[pos];
            r.bucket_size = bkt_size[pos];
          end else r.error = 1;
        end
        rbp_pkg::OP_CLEAR: begin
          fill = 0;
          ord_cnt = 0;
          clamp = 0;
          foreach (bkt_size[i]) begin
            bkt_size[i] = 0;
            bkt_start[i] = 0;
          end
        end
        default: r.error = 1;
      endcase
      r.item_count = rbp_pkg::CNT_W'(fill);
      pending.push_back(r);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat item_count %0d", $time, got.item_count);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (got.key_out !== e.key_out) begin
        $display("%0t: key_out exp %h got %h", $time, e.key_out, got.key_out);
        mismatches++;
      end
      if (got.value_out !== e.value_out) begin
        $display("%0t: value_out exp %h got %h", $time, e.value_out, got.value_out);
        mismatches++;
      end
      if (got.bucket_start !== e.bucket_start) begin
        $display("%0t: bucket_start exp %0d got %0d", $time, e.bucket_start,
                 got.bucket_start);
        mismatches++;
      end
      if (got.bucket_size !== e.bucket_size) begin
        $display("%0t: bucket_size exp %0d got %0d", $time, e.bucket_size,
                 got.bucket_size);
        mismatches++;
      end
      if (got.item_count !== e.item_count) begin
        $display("%0t: item_count exp %0d got %0d", $time, e.item_count, got.item_count);
        mismatches++;
      end
      if (got.error !== e.error) begin
        $display("%0t: error exp %b got %b", $time, e.error, got.error);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [rbp_pkg::ADDR_W-1:0] paddr;
  logic [rbp_pkg::DATA_W-1:0] pwdata, prdata;
  bit quiet;
  int unsigned cycles;

  rbp_req_if req();
  rbp_rsp_if rsp();

  partition_scoreboard sb = new();

  range_bucket_partitioner #(.MAX_ITEMS(MAX_ITEMS), .MAX_BUCKETS(MAX_BUCKETS)) DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("range_bucket_partitioner test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.key_out = rsp.key_out;
      got.value_out = rsp.value_out;
      got.bucket_start = rsp.bucket_start;
      got.bucket_size = rsp.bucket_size;
      got.item_count = rsp.item_count;
      got.error = rsp.error;
      sb.check_result(got);
    end
  end

  initial begin
    rsp.ready <= 0;
    @(posedge clk);
    forever begin
      rsp.ready <= 1;
      repeat ($urandom_range(30, 1)) @(posedge clk);
      if (!quiet && $urandom_range(1) == 1) begin
        rsp.ready <= 0;
        repeat ($urandom_range(14, 1)) @(posedge clk);
      end
    end
  end

  task automatic send(rbp_pkg::op_t op, logic [31:0] k, logic [31:0] v,
                      logic [rbp_pkg::POS_W-1:0] pos);
    if (!quiet && $urandom_range(3) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    req.valid <= 1;
    req.op <= op;
    req.key <= k;
    req.value <= v;
    req.position <= pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(op, k, v, pos);
  endtask

  task automatic drain();
    req.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(rbp_pkg::reg_idx_t idx, logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [31:0] lo, logic [31:0] hi,
                           logic [rbp_pkg::BC_W-1:0] nb);
    reg_write(rbp_pkg::REG_BEGIN, lo);
    reg_write(rbp_pkg::REG_END, hi);
    reg_write(rbp_pkg::REG_BCNT, {25'b0, nb});
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    logic [31:0] span;
    span = sb.rng_hi - sb.rng_lo;
    if ($signed(sb.rng_hi) > $signed(sb.rng_lo) && $urandom_range(9) < 8)
      return sb.rng_lo + 32'(({32'b0, $urandom()} % {32'b0, span}));
    return $urandom();
  endfunction

  task automatic random_beat();
    int unsigned sel;
    rbp_pkg::op_t bad;
    logic [rbp_pkg::POS_W-1:0] pos;
    sel = $urandom_range(99);
    bad = rbp_pkg::OP_CLEAR + rbp_pkg::op_t'($urandom_range(3, 1));
    if (sel < 40)
      send(rbp_pkg::OP_LOAD, pick_key(), $urandom(), rbp_pkg::POS_W'($urandom()));
    else if (sel < 70) begin
      pos = (sb.ord_cnt > 0 && $urandom_range(4) > 0) ?
            rbp_pkg::POS_W'($urandom_range(sb.ord_cnt - 1)) : rbp_pkg::POS_W'($urandom());
      send(rbp_pkg::OP_RD_PAIR, $urandom(), $urandom(), pos);
    end else if (sel < 90) begin
      pos = ($urandom_range(4) > 0) ? rbp_pkg::POS_W'($urandom_range(sb.eff_buckets()))
                                    : rbp_pkg::POS_W'($urandom());
      send(rbp_pkg::OP_RD_BKT, $urandom(), $urandom(), pos);
    end else if (sel < 95)
      send(rbp_pkg::OP_PART, $urandom(), $urandom(), rbp_pkg::POS_W'($urandom()));
    else if (sel < 98)
      send(bad, $urandom(), $urandom(), rbp_pkg::POS_W'($urandom()));
    else
      send(rbp_pkg::OP_CLEAR, $urandom(), $urandom(), rbp_pkg::POS_W'($urandom()));
  endtask

  task automatic run_phase(int unsigned loads, int unsigned reads);
    send(rbp_pkg::OP_CLEAR, 0, 0, 0);
    repeat (loads)
      send(rbp_pkg::OP_LOAD, pick_key(), $urandom(), rbp_pkg::POS_W'($urandom()));
    send(rbp_pkg::OP_PART, $urandom(), $urandom(), rbp_pkg::POS_W'($urandom()));
    repeat (reads) random_beat();
    send(rbp_pkg::OP_PART, 0, 0, 0);
    for (int b = 0; b < sb.eff_buckets() && b < 4; b++)
      send(rbp_pkg::OP_RD_BKT, 0, 0, rbp_pkg::POS_W'(b));
  endtask

  initial begin
    logic [31:0] lo, hi;
    rst <= 1;
    quiet = 0;
    cycles = 0;
    req.valid <= 0;
    req.op <= rbp_pkg::OP_LOAD;
    req.key <= 0;
    req.value <= 0;
    req.position <= 0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= 0;
    pwdata <= 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    configure(-32'sd100, 32'sd100, 4);
    send(rbp_pkg::OP_RD_PAIR, 0, 0, 0);
    send(rbp_pkg::OP_RD_BKT, 0, 0, 0);
    send(rbp_pkg::OP_LOAD, 32'h8000_0000, 32'h8000_0000, 10'h3ff);
    send(rbp_pkg::OP_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send(rbp_pkg::OP_LOAD, -32'sd100, 32'hffff_ffff, 0);
    send(rbp_pkg::OP_LOAD, 32'sd99, 32'h0, 0);
    send(rbp_pkg::OP_LOAD, 32'sd100, 32'h1234_5678, 0);
    send(rbp_pkg::OP_LOAD, 32'sd0, 32'h5555_aaaa, 0);
    send(rbp_pkg::OP_LOAD, -32'sd1, 32'haaaa_5555, 0);
    send(rbp_pkg::OP_PART, 0, 0, 0);
    for (int i = 0; i < 7; i++) send(rbp_pkg::OP_RD_PAIR, 0, 0, rbp_pkg::POS_W'(i));
    send(rbp_pkg::OP_RD_PAIR, 0, 0, 10'd7);
    send(rbp_pkg::OP_RD_PAIR, 0, 0, 10'h3ff);
    send(rbp_pkg::OP_RD_BKT, 0, 0, 10'd3);
    send(rbp_pkg::OP_RD_BKT, 0, 0, 10'd4);
    send(rbp_pkg::OP_RD_BKT, 0, 0, 10'h3ff);
    send(rbp_pkg::OP_CLEAR + rbp_pkg::op_t'(1), 0, 0, 0);
    send(rbp_pkg::OP_CLEAR + rbp_pkg::op_t'(3), 0, 0, 0);
    send(rbp_pkg::OP_CLEAR, 0, 0, 0);
    send(rbp_pkg::OP_PART, 0, 0, 0);
    drain();

    for (int p = 0; p < 24; p++) begin
      case (p % 6)
        0: configure(-32'sd100, 32'sd100, 4);
        1: configure(32'h8000_0000, 32'h7fff_ffff, 64);
        2: begin
          lo = $urandom();
          hi = lo + $urandom_range(5000, 1);
          if ($signed(hi) <= $signed(lo)) hi = 32'h7fff_ffff;
          configure(lo, hi, rbp_pkg::BC_W'($urandom_range(64, 1)));
        end
        3: configure(5, 5, 127);
        4: configure(0, 1, 0);
        default: configure($urandom(), $urandom(), rbp_pkg::BC_W'($urandom_range(127)));
      endcase
      run_phase($urandom_range(3) == 0 ? $urandom_range(2) : $urandom_range(40, 3),
                $urandom_range(20, 5));
      drain();
    end

    quiet = 1;
    configure(32'h8000_0000, 32'h7fff_ffff, 1);
    run_phase(20, 30);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("range_bucket_partitioner test passed");
    else
      $display("range_bucket_partitioner test failed");
    $finish;
  end

endmodule
